// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the quad flattening block. The enclosing
// module must have a clock named clk and an active-low reset named arst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QFTP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define QFTP_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define QFTP_ASSERT(lbl, prop, msg)
`define QFTP_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: hdl/qftp_pkg.sv
// ---------------------------------------------------------------------------
// qftp_pkg
// Widths, payload types and helpers shared by the quad flattening pipeline.
// ---------------------------------------------------------------------------
package qftp_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIFF_W     = COORD_BITS + 1;   // edge vector component
	localparam int SQ_W       = 2 * DIFF_W;       // squared component / cross term
	localparam int NORM_W     = SQ_W + 2;         // squared norm
	localparam int XD_W       = SQ_W + 1;         // cross component before magnitude
	localparam int XM_W       = SQ_W;             // cross component magnitude
	localparam int XSQ_W      = 2 * XM_W;         // squared cross component
	localparam int NUM_W      = XSQ_W + 2;        // squared cross norm
	localparam int ROOT_W     = NORM_W / 2;       // square root of a norm-sized value
	localparam int OUT_W      = 17;
	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [OUT_W-1:0] dist_t;

	typedef struct packed {
		coord_t p0_x;
		coord_t p0_y;
		coord_t p0_z;
		coord_t p1_x;
		coord_t p1_y;
		coord_t p1_z;
		coord_t p2_x;
		coord_t p2_y;
		coord_t p2_z;
		coord_t p3_x;
		coord_t p3_y;
		coord_t p3_z;
	} corners_t;

	typedef struct packed {
		dist_t edge_length;
		dist_t c2_along;
		dist_t c2_across;
		dist_t c3_along;
		dist_t c3_across;
		logic  degenerate;
	} plane_t;

	typedef struct packed {
		logic [NUM_W-1:0]  num2;
		logic [NUM_W-1:0]  num3;
		logic [NORM_W-1:0] nrm1;
		logic [NORM_W-1:0] nrm2;
		logic [NORM_W-1:0] nrm3;
		logic              degenerate;
	} front_t;

	// Clamp a root to the output range.
	function automatic dist_t sat_root(input logic [ROOT_W-1:0] r);
		return (r > ROOT_W'(OUT_MAX)) ? OUT_MAX : r[OUT_W-1:0];
	endfunction

endpackage

// File: hdl/qftp_front.sv
// ---------------------------------------------------------------------------
// qftp_front
// Five-stage front end: edge vectors, squared norms and squared cross norms.
// ---------------------------------------------------------------------------
module qftp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  qftp_pkg::corners_t corners,
	output logic               out_valid,
	output qftp_pkg::front_t   out
);

	localparam int CB  = qftp_pkg::COORD_BITS;
	localparam int DW  = qftp_pkg::DIFF_W;
	localparam int SW  = qftp_pkg::SQ_W;
	localparam int NW  = qftp_pkg::NORM_W;
	localparam int XDW = qftp_pkg::XD_W;
	localparam int XMW = qftp_pkg::XM_W;
	localparam int XSW = qftp_pkg::XSQ_W;
	localparam int UW  = qftp_pkg::NUM_W;

	logic signed [CB-1:0]  p [4][3];
	logic signed [DW-1:0]  vec_s1 [3][3];
	logic signed [SW-1:0]  sq_s2 [3][3];
	logic signed [SW-1:0]  xa_s2 [2][3];
	logic signed [SW-1:0]  xb_s2 [2][3];
	logic [NW-1:0]         nrm_s3 [3];
	logic [XMW-1:0]        xm_s3 [2][3];
	logic [XMW-1:0]        xm_c [2][3];
	logic [NW-1:0]         nrm_s4 [3];
	logic [XSW-1:0]        xsq_s4 [2][3];
	logic [NW-1:0]         nrm_s5 [3];
	logic [UW-1:0]         num_s5 [2];
	logic                  dg_s5;
	logic                  v_s1, v_s2, v_s3, v_s4, v_s5;

	// Gather corner coordinates
	assign p[0][0] = corners.p0_x;
	assign p[0][1] = corners.p0_y;
	assign p[0][2] = corners.p0_z;
	assign p[1][0] = corners.p1_x;
	assign p[1][1] = corners.p1_y;
	assign p[1][2] = corners.p1_z;
	assign p[2][0] = corners.p2_x;
	assign p[2][1] = corners.p2_y;
	assign p[2][2] = corners.p2_z;
	assign p[3][0] = corners.p3_x;
	assign p[3][1] = corners.p3_y;
	assign p[3][2] = corners.p3_z;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: edge vectors relative to corner 0
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				vec_s1[k][i] <= $signed({p[k+1][i][CB-1], p[k+1][i]})
				              - $signed({p[0][i][CB-1], p[0][i]});
			end
		end
	end

	// Stage 2: component squares and cross product terms against edge 1
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[k][i] <= vec_s1[k][i] * vec_s1[k][i];
			end
		end
		for (int k = 0; k < 2; k++) begin
			xa_s2[k][0] <= vec_s1[k+1][1] * vec_s1[0][2];
			xb_s2[k][0] <= vec_s1[k+1][2] * vec_s1[0][1];
			xa_s2[k][1] <= vec_s1[k+1][0] * vec_s1[0][2];
			xb_s2[k][1] <= vec_s1[k+1][2] * vec_s1[0][0];
			xa_s2[k][2] <= vec_s1[k+1][0] * vec_s1[0][1];
			xb_s2[k][2] <= vec_s1[k+1][1] * vec_s1[0][0];
		end
	end

	// Cross components and their magnitudes
	always_comb begin
		logic signed [XDW-1:0] d;
		for (int k = 0; k < 2; k++) begin
			for (int j = 0; j < 3; j++) begin
				d = $signed({xa_s2[k][j][SW-1], xa_s2[k][j]})
				  - $signed({xb_s2[k][j][SW-1], xb_s2[k][j]});
				xm_c[k][j] = d[XDW-1] ? XMW'(-d) : XMW'(d);
			end
		end
	end

	// Stage 3: squared norms, cross magnitudes
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			nrm_s3[k] <= {2'b00, sq_s2[k][0]} + {2'b00, sq_s2[k][1]}
			           + {2'b00, sq_s2[k][2]};
		end
		xm_s3 <= xm_c;
	end

	// Stage 4: square the cross components
	always_ff @(posedge clk) begin
		nrm_s4 <= nrm_s3;
		for (int k = 0; k < 2; k++) begin
			for (int j = 0; j < 3; j++) begin
				xsq_s4[k][j] <= xm_s3[k][j] * xm_s3[k][j];
			end
		end
	end

	// Stage 5: squared cross norms, coincident-edge flag
	always_ff @(posedge clk) begin
		nrm_s5 <= nrm_s4;
		dg_s5  <= (nrm_s4[0] == '0);
		for (int k = 0; k < 2; k++) begin
			num_s5[k] <= {2'b00, xsq_s4[k][0]} + {2'b00, xsq_s4[k][1]}
			           + {2'b00, xsq_s4[k][2]};
		end
	end

	assign out_valid      = v_s5;
	assign out.num2       = num_s5[0];
	assign out.num3       = num_s5[1];
	assign out.nrm1       = nrm_s5[0];
	assign out.nrm2       = nrm_s5[1];
	assign out.nrm3       = nrm_s5[2];
	assign out.degenerate = dg_s5;

endmodule

// File: hdl/qftp_div.sv
// ---------------------------------------------------------------------------
// qftp_div
// Pipelined restoring divider, STEPS quotient bits per stage, with sideband.
// ---------------------------------------------------------------------------
module qftp_div #(
	parameter int NUM_W  = 70,
	parameter int DEN_W  = 36,
	parameter int QUO_W  = 36,
	parameter int STEPS  = 2,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [QUO_W-1:0]  quo,
	output logic [SIDE_W-1:0] out_side
);

	localparam int NSTG = (QUO_W + STEPS - 1) / STEPS;

	logic [DEN_W-1:0]  src_rem  [NSTG];
	logic [QUO_W-1:0]  src_lo   [NSTG];
	logic [DEN_W-1:0]  src_den  [NSTG];
	logic [SIDE_W-1:0] src_side [NSTG];
	logic              src_vld  [NSTG];
	logic [DEN_W-1:0]  rem_s    [NSTG];
	logic [QUO_W-1:0]  lo_s     [NSTG];
	logic [DEN_W-1:0]  den_s    [NSTG];
	logic [SIDE_W-1:0] side_s   [NSTG];
	logic              vld_s    [NSTG];

	// Load the quotient-sized low part; the high part is below the divisor
	assign src_rem[0]  = DEN_W'(num >> QUO_W);
	assign src_lo[0]   = num[QUO_W-1:0];
	assign src_den[0]  = den;
	assign src_side[0] = in_side;
	assign src_vld[0]  = in_valid;

	genvar g;
	for (g = 0; g < NSTG; g++) begin : g_stg
		logic [DEN_W-1:0] rem_c;
		logic [QUO_W-1:0] lo_c;

		if (g > 0) begin : g_link
			assign src_rem[g]  = rem_s[g-1];
			assign src_lo[g]   = lo_s[g-1];
			assign src_den[g]  = den_s[g-1];
			assign src_side[g] = side_s[g-1];
			assign src_vld[g]  = vld_s[g-1];
		end

		// Shift in one numerator bit per step, subtract where it fits
		always_comb begin
			logic [DEN_W:0] t;
			logic           qb;
			rem_c = src_rem[g];
			lo_c  = src_lo[g];
			for (int k = 0; k < STEPS; k++) begin
				if (g * STEPS + k < QUO_W) begin
					t = {rem_c, lo_c[QUO_W-1]};
					if (t >= {1'b0, src_den[g]}) begin
						t  = t - {1'b0, src_den[g]};
						qb = 1'b1;
					end else begin
						qb = 1'b0;
					end
					rem_c = t[DEN_W-1:0];
					lo_c  = {lo_c[QUO_W-2:0], qb};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= src_vld[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g]  <= rem_c;
			lo_s[g]   <= lo_c;
			den_s[g]  <= src_den[g];
			side_s[g] <= src_side[g];
		end
	end

	assign out_valid = vld_s[NSTG-1];
	assign quo       = lo_s[NSTG-1];
	assign out_side  = side_s[NSTG-1];

endmodule

// File: hdl/qftp_sqrt.sv
// ---------------------------------------------------------------------------
// qftp_sqrt
// Pipelined digit-by-digit floor square root, STEPS root bits per stage.
// ---------------------------------------------------------------------------
module qftp_sqrt #(
	parameter int RAD_W  = 36,
	parameter int STEPS  = 2,
	parameter int SIDE_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [RAD_W-1:0]     rad,
	input  logic [SIDE_W-1:0]    in_side,
	output logic                 out_valid,
	output logic [RAD_W/2-1:0]   root,
	output logic [SIDE_W-1:0]    out_side
);

	localparam int RTW  = RAD_W / 2;
	localparam int NSTG = (RTW + STEPS - 1) / STEPS;

	logic [RTW:0]      src_rem  [NSTG];
	logic [RTW-1:0]    src_root [NSTG];
	logic [RAD_W-1:0]  src_x    [NSTG];
	logic [SIDE_W-1:0] src_side [NSTG];
	logic              src_vld  [NSTG];
	logic [RTW:0]      rem_s    [NSTG];
	logic [RTW-1:0]    root_s   [NSTG];
	logic [RAD_W-1:0]  x_s      [NSTG];
	logic [SIDE_W-1:0] side_s   [NSTG];
	logic              vld_s    [NSTG];

	assign src_rem[0]  = '0;
	assign src_root[0] = '0;
	assign src_x[0]    = rad;
	assign src_side[0] = in_side;
	assign src_vld[0]  = in_valid;

	genvar g;
	for (g = 0; g < NSTG; g++) begin : g_stg
		logic [RTW:0]     rem_c;
		logic [RTW-1:0]   root_c;
		logic [RAD_W-1:0] x_c;

		if (g > 0) begin : g_link
			assign src_rem[g]  = rem_s[g-1];
			assign src_root[g] = root_s[g-1];
			assign src_x[g]    = x_s[g-1];
			assign src_side[g] = side_s[g-1];
			assign src_vld[g]  = vld_s[g-1];
		end

		// Bring down two radicand bits, try root*4+1
		always_comb begin
			logic [RTW+1:0] r;
			logic [RTW+1:0] trial;
			rem_c  = src_rem[g];
			root_c = src_root[g];
			x_c    = src_x[g];
			for (int k = 0; k < STEPS; k++) begin
				if (g * STEPS + k < RTW) begin
					r     = {rem_c[RTW-1:0], x_c[RAD_W-1 -: 2]};
					trial = {root_c, 2'b01};
					if (r >= trial) begin
						rem_c  = (RTW+1)'(r - trial);
						root_c = {root_c[RTW-2:0], 1'b1};
					end else begin
						rem_c  = r[RTW:0];
						root_c = {root_c[RTW-2:0], 1'b0};
					end
					x_c = {x_c[RAD_W-3:0], 2'b00};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= src_vld[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g]  <= rem_c;
			root_s[g] <= root_c;
			x_s[g]    <= x_c;
			side_s[g] <= src_side[g];
		end
	end

	assign out_valid = vld_s[NSTG-1];
	assign root      = root_s[NSTG-1];
	assign out_side  = side_s[NSTG-1];

endmodule

// File: hdl/quad_flatten_to_plane_core.sv
// Throughput: one face per cycle; busy is never raised.
// Depth: 5 front stages, 18 divider stages, 1 radicand stage,
// 9 square-root stages and the result register.
// Reset clears only the valid bits; results in flight are dropped.
// ---------------------------------------------------------------------------
// quad_flatten_to_plane_core
// Lays a 3D quadrilateral flat: edge length plus along/across distances of
// corners 2 and 3 relative to the first edge.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module quad_flatten_to_plane_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  qftp_pkg::corners_t corners,
	output logic               done,
	output qftp_pkg::plane_t   plane
);

	localparam int NW      = qftp_pkg::NORM_W;
	localparam int RTW     = qftp_pkg::ROOT_W;
	localparam int LATENCY = 34;

	qftp_pkg::front_t  fr;
	logic              fr_v;
	logic              dv2, dv3;
	logic [NW-1:0]     quo2, quo3;
	logic [2*NW:0]     side2;
	logic [NW-1:0]     side3;
	logic [NW-1:0]     n2_d, n1_d;
	logic              dg_d;
	logic [NW-1:0]     rad2_s24, q2_s24, rad3_s24, q3_s24, n1_s24;
	logic              dg_s24, vld_s24;
	logic [RTW-1:0]    rt [5];
	logic              sq_v;
	logic              sq_dg;
	qftp_pkg::plane_t  res_s34;
	logic              done_s34;
	logic              dist_zero;

	assign busy = 1'b0;

	qftp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.corners   (corners),
		.out_valid (fr_v),
		.out       (fr)
	);

	// Squared cross norm over squared edge length, per corner
	qftp_div #(
		.NUM_W  (qftp_pkg::NUM_W),
		.DEN_W  (NW),
		.QUO_W  (NW),
		.STEPS  (2),
		.SIDE_W (2 * NW + 1)
	) u_div2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_v),
		.num       (fr.num2),
		.den       (fr.nrm1),
		.in_side   ({fr.nrm2, fr.nrm1, fr.degenerate}),
		.out_valid (dv2),
		.quo       (quo2),
		.out_side  (side2)
	);

	qftp_div #(
		.NUM_W  (qftp_pkg::NUM_W),
		.DEN_W  (NW),
		.QUO_W  (NW),
		.STEPS  (2),
		.SIDE_W (NW)
	) u_div3 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_v),
		.num       (fr.num3),
		.den       (fr.nrm1),
		.in_side   (fr.nrm3),
		.out_valid (dv3),
		.quo       (quo3),
		.out_side  (side3)
	);

	assign {n2_d, n1_d, dg_d} = side2;

	// Along radicands, clamped at zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s24 <= 1'b0;
		end else begin
			vld_s24 <= dv2;
		end
	end

	always_ff @(posedge clk) begin
		q2_s24   <= quo2;
		q3_s24   <= quo3;
		rad2_s24 <= (quo2 > n2_d) ? '0 : n2_d - quo2;
		rad3_s24 <= (quo3 > side3) ? '0 : side3 - quo3;
		n1_s24   <= n1_d;
		dg_s24   <= dg_d;
	end

	// Five square-root lanes; lane 0 carries the valid and the flag
	qftp_sqrt #(.RAD_W(NW), .STEPS(2), .SIDE_W(1)) u_sq_edge (
		.clk (clk), .arst_n (arst_n), .in_valid (vld_s24), .rad (n1_s24),
		.in_side (dg_s24), .out_valid (sq_v), .root (rt[0]), .out_side (sq_dg)
	);
	qftp_sqrt #(.RAD_W(NW), .STEPS(2), .SIDE_W(1)) u_sq_al2 (
		.clk (clk), .arst_n (arst_n), .in_valid (vld_s24), .rad (rad2_s24),
		.in_side (dg_s24), .out_valid (), .root (rt[1]), .out_side ()
	);
	qftp_sqrt #(.RAD_W(NW), .STEPS(2), .SIDE_W(1)) u_sq_ac2 (
		.clk (clk), .arst_n (arst_n), .in_valid (vld_s24), .rad (q2_s24),
		.in_side (dg_s24), .out_valid (), .root (rt[2]), .out_side ()
	);
	qftp_sqrt #(.RAD_W(NW), .STEPS(2), .SIDE_W(1)) u_sq_al3 (
		.clk (clk), .arst_n (arst_n), .in_valid (vld_s24), .rad (rad3_s24),
		.in_side (dg_s24), .out_valid (), .root (rt[3]), .out_side ()
	);
	qftp_sqrt #(.RAD_W(NW), .STEPS(2), .SIDE_W(1)) u_sq_ac3 (
		.clk (clk), .arst_n (arst_n), .in_valid (vld_s24), .rad (q3_s24),
		.in_side (dg_s24), .out_valid (), .root (rt[4]), .out_side ()
	);

	// Result register: saturate, zero all distances on a coincident edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s34 <= 1'b0;
		end else begin
			done_s34 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		res_s34.edge_length <= sq_dg ? '0 : qftp_pkg::sat_root(rt[0]);
		res_s34.c2_along    <= sq_dg ? '0 : qftp_pkg::sat_root(rt[1]);
		res_s34.c2_across   <= sq_dg ? '0 : qftp_pkg::sat_root(rt[2]);
		res_s34.c3_along    <= sq_dg ? '0 : qftp_pkg::sat_root(rt[3]);
		res_s34.c3_across   <= sq_dg ? '0 : qftp_pkg::sat_root(rt[4]);
		res_s34.degenerate  <= sq_dg;
	end

	assign done  = done_s34;
	assign plane = res_s34;

	// All five distances of the current result are zero
	assign dist_zero = (plane.edge_length == '0) && (plane.c2_along == '0)
	                 && (plane.c2_across == '0) && (plane.c3_along == '0)
	                 && (plane.c3_across == '0);

	`QFTP_ASSERT(a_latency, start |-> ##LATENCY done, "transfer without result")
	`QFTP_ASSERT(a_no_phantom, done |-> $past(start, LATENCY), "result without transfer")
	`QFTP_ASSERT(a_degen_zero, (done && plane.degenerate) |-> dist_zero, "distance on degenerate face")
	`QFTP_ASSERT_NEVER(a_quo_bound, dv2 && !dg_d && (quo2 > n2_d), "quotient above norm")
	`QFTP_ASSERT(a_lane_sync, dv3 == dv2, "divider lanes out of step")

endmodule

// File: sim/tb.sv
// ---------------------------------------------------------------------------
// Testbench for quad_flatten_to_plane_core
// Drives faces through the command interface at random gaps, predicts the
// flat corner distances with exact integer arithmetic and checks each done
// strobe against the oldest predicted face, field by field.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY   = 34;
	localparam int CYCLE_MAX = 200000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	qftp_pkg::corners_t corners;
	logic               done;
	qftp_pkg::plane_t   plane;

	quad_flatten_to_plane_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.corners (corners),
		.done    (done),
		.plane   (plane)
	);

	qftp_pkg::corners_t face_queue[$];
	qftp_pkg::plane_t   plane_expected[$];
	int                 mismatch_count;
	int                 cycle_count;
	bit                 no_idle;

	// Clock: 2 ns period
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Append one face to the stimulus queue
	task automatic queue_face(input qftp_pkg::corners_t f);
		face_queue = {face_queue, f};
	endtask

	// Floor square root of an exact unsigned value
	function automatic longint unsigned isqrt(input logic [127:0] x);
		logic [127:0] r;
		logic [127:0] b;
		r = 0;
		b = 128'd1 << 126;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r[63:0];
	endfunction

	function automatic qftp_pkg::dist_t clamp_dist(input longint unsigned v);
		return (v > 64'(qftp_pkg::OUT_MAX)) ? qftp_pkg::OUT_MAX : qftp_pkg::dist_t'(v);
	endfunction

	// Place one corner relative to the first edge
	function automatic void place_corner(input longint signed vk[3],
			input longint signed v1[3], input logic [127:0] n1,
			output qftp_pkg::dist_t along, output qftp_pkg::dist_t across);
		logic signed [127:0] c0, c1, c2;
		logic [127:0] s, q, nk, rad;
		c0 = vk[1] * v1[2] - vk[2] * v1[1];
		c1 = vk[0] * v1[2] - vk[2] * v1[0];
		c2 = vk[0] * v1[1] - vk[1] * v1[0];
		s = 128'(c0 * c0) + 128'(c1 * c1);
		s = s + 128'(c2 * c2);
		q = s / n1;
		nk = 128'(vk[0] * vk[0] + vk[1] * vk[1] + vk[2] * vk[2]);
		rad = (q > nk) ? 128'd0 : nk - q;
		along = clamp_dist(isqrt(rad));
		across = clamp_dist(isqrt(q));
	endfunction

	// Compute the flat layout of a face
	function automatic qftp_pkg::plane_t flatten_face(input qftp_pkg::corners_t c);
		longint signed pt[4][3];
		longint signed v[3][3];
		logic [127:0] n1;
		qftp_pkg::plane_t r;
		pt[0] = '{c.p0_x, c.p0_y, c.p0_z};
		pt[1] = '{c.p1_x, c.p1_y, c.p1_z};
		pt[2] = '{c.p2_x, c.p2_y, c.p2_z};
		pt[3] = '{c.p3_x, c.p3_y, c.p3_z};
		for (int k = 0; k < 3; k++)
			for (int i = 0; i < 3; i++)
				v[k][i] = pt[k+1][i] - pt[0][i];
		n1 = 128'(v[0][0] * v[0][0] + v[0][1] * v[0][1] + v[0][2] * v[0][2]);
		r = '0;
		if (n1 == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		r.edge_length = clamp_dist(isqrt(n1));
		place_corner(v[1], v[0], n1, r.c2_along, r.c2_across);
		place_corner(v[2], v[0], n1, r.c3_along, r.c3_across);
		return r;
	endfunction

	task automatic report_mismatch(input string field, input longint unsigned got,
			input longint unsigned want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d",
			cycle_count, field, got, want);
		mismatch_count++;
	endtask

	function automatic qftp_pkg::coord_t rand_coord();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return qftp_pkg::coord_t'($urandom_range(0, 64)) - 16'sd32;
			default: return qftp_pkg::coord_t'($urandom);
		endcase
	endfunction

	function automatic qftp_pkg::corners_t rand_face();
		qftp_pkg::corners_t c;
		c = qftp_pkg::corners_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom});
		if ($urandom_range(0, 1)) begin
			c.p0_x = rand_coord(); c.p0_y = rand_coord(); c.p0_z = rand_coord();
			c.p1_x = rand_coord(); c.p1_y = rand_coord(); c.p1_z = rand_coord();
			c.p2_x = rand_coord(); c.p2_y = rand_coord(); c.p2_z = rand_coord();
			c.p3_x = rand_coord(); c.p3_y = rand_coord(); c.p3_z = rand_coord();
		end
		// make a few first edges collapse
		if ($urandom_range(0, 19) == 0) begin
			c.p1_x = c.p0_x; c.p1_y = c.p0_y; c.p1_z = c.p0_z;
		end
		return c;
	endfunction

	// Driver: pop the next face on each accepted transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			corners <= '0;
		end else begin
			if (start && !busy) begin
				plane_expected = {plane_expected, flatten_face(corners)};
			end
			if ((start && !busy) || !start) begin
				if (face_queue.size() > 0 && (no_idle || $urandom_range(0, 99) >= 29)) begin
					start <= 1'b1;
					corners <= face_queue.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each done strobe against the oldest prediction
	always @(posedge clk) begin
		qftp_pkg::plane_t want;
		cycle_count <= cycle_count + 1;
		if (arst_n && done) begin
			if (plane_expected.size() == 0) begin
				report_mismatch("unexpected done", 1, 0);
			end else begin
				want = plane_expected.pop_front();
				if (plane.edge_length !== want.edge_length)
					report_mismatch("edge_length", plane.edge_length, want.edge_length);
				if (plane.c2_along !== want.c2_along)
					report_mismatch("c2_along", plane.c2_along, want.c2_along);
				if (plane.c2_across !== want.c2_across)
					report_mismatch("c2_across", plane.c2_across, want.c2_across);
				if (plane.c3_along !== want.c3_along)
					report_mismatch("c3_along", plane.c3_along, want.c3_along);
				if (plane.c3_across !== want.c3_across)
					report_mismatch("c3_across", plane.c3_across, want.c3_across);
				if (plane.degenerate !== want.degenerate)
					report_mismatch("degenerate", plane.degenerate, want.degenerate);
			end
		end
	end

	// Timeout
	always @(posedge clk) begin
		if (cycle_count >= CYCLE_MAX) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		qftp_pkg::corners_t c;
		mismatch_count = 0;
		cycle_count = 0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		// Directed faces: extremes, collapsed edge, collinear, right angle
		queue_face('0);
		queue_face({12{16'sh7fff}});
		queue_face({12{16'sh8000}});
		c = '0; c.p1_x = 16'sh7fff; c.p2_x = 16'sh8000; c.p3_y = 16'sh7fff;
		queue_face(c);
		c = '0; c.p0_x = 16'sh8000; c.p0_y = 16'sh8000; c.p0_z = 16'sh8000;
		c.p1_x = 16'sh7fff; c.p1_y = 16'sh7fff; c.p1_z = 16'sh7fff;
		c.p2_x = 16'sh7fff; c.p2_y = 16'sh8000; c.p2_z = 16'sh7fff;
		c.p3_x = 16'sh8000; c.p3_y = 16'sh7fff; c.p3_z = 16'sh8000;
		queue_face(c);
		c = '0; c.p1_x = 16'sd256; c.p2_x = 16'sd256; c.p2_y = 16'sd256;
		c.p3_y = 16'sd256;
		queue_face(c);
		c = '0; c.p1_x = 16'sd1; c.p1_y = 16'sd1; c.p2_x = 16'sd3; c.p2_y = 16'sd3;
		c.p3_x = -16'sd5; c.p3_y = -16'sd5;
		queue_face(c);
		c = '0; c.p1_z = 16'sd1; c.p2_x = 16'sh7fff; c.p3_y = 16'sh8000;
		queue_face(c);
		c = {12{16'sh1234}}; c.p2_x = 16'sh8000; c.p3_z = 16'sh7fff;
		queue_face(c);
		c = {12{16'shffff}}; c.p1_y = 16'sh0000;
		queue_face(c);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		for (int n = 0; n < 500; n++) queue_face(rand_face());
		// stretch without gaps in the middle of the run
		while (face_queue.size() >= 300) @(posedge clk);
		no_idle = 1'b1;
		while (face_queue.size() >= 150) @(posedge clk);
		no_idle = 1'b0;
		while (face_queue.size() != 0 || start) @(posedge clk);
		while (plane_expected.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
